>>> hdl/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FRAME_LEN  = 10;
  localparam int unsigned STORED_LEN = 9;
  localparam int unsigned BODY_LEN   = 8;   // frame bytes 1..8 carried out with a result
  localparam int unsigned POS_W      = 4;
  localparam int unsigned BODY_IDX_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [POS_W-1:0]  LAST_POS     = POS_W'(FRAME_LEN - 1);
  localparam logic [BYTE_W-1:0] CSUM_ADJUST  = 8'h01;

  localparam logic [BYTE_W-1:0] STATION_RST   = 8'd2;
  localparam logic [BYTE_W-1:0] START_RST     = 8'd2;
  localparam logic [BYTE_W-1:0] BROADCAST_RST = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATION   = 2'd0,
    REG_START     = 2'd1,
    REG_BROADCAST = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] station_address;
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] broadcast_address;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_address;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] frame_rate;
    logic [BYTE_W-1:0] packet_seq;
    logic [BYTE_W-1:0] data_zero;
    logic [BYTE_W-1:0] data_one;
    logic [BYTE_W-1:0] data_two;
    logic [BYTE_W-1:0] data_three;
    logic              is_broadcast;
  } frame_t;

endpackage

`default_nettype wire

>>> hdl/fpr_assembler.sv
`default_nettype none

module fpr_assembler (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      byte_take,
  input  wire logic [fpr_pkg::BYTE_W-1:0] rx_byte,
  input  wire fpr_pkg::cfg_t             cfg,
  output logic                           at_last,
  output logic                           frame_hit,
  output fpr_pkg::frame_t                frame
);
  import fpr_pkg::*;

  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_eff;
  logic [POS_W-1:0]      pos_next;
  logic [BYTE_W-1:0]     byte0;
  logic [BYTE_W-1:0]     byte0_cur;
  logic [BYTE_W-1:0]     sum;
  logic [BYTE_W-1:0]     csum;
  logic [BYTE_W-1:0]     body [BODY_LEN];
  logic [BODY_IDX_W-1:0] wr_idx;
  logic                  in_sync;
  logic                  addr_ok;

  // positions past the end cannot arise, but treat them as the start of a frame
  assign pos_eff   = (pos > LAST_POS) ? '0 : pos;
  assign byte0_cur = (pos_eff == '0) ? rx_byte : byte0;
  assign in_sync   = (byte0_cur == cfg.start_byte);
  assign at_last   = (pos_eff == LAST_POS);
  assign wr_idx    = BODY_IDX_W'(pos_eff - POS_W'(1));

  // the checksum avoids the start byte by stepping one below it
  assign csum    = (sum == cfg.start_byte) ? sum - CSUM_ADJUST : sum;
  assign addr_ok = (body[0] == cfg.station_address) || (body[0] == cfg.broadcast_address);

  always_comb begin
    if (!in_sync || at_last) begin
      pos_next = '0;
    end else begin
      pos_next = pos_eff + POS_W'(1);
    end
  end

  assign frame_hit = byte_take && in_sync && at_last && (csum == rx_byte) && addr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (byte_take) begin
      pos <= pos_next;
    end
  end

  // store every word before the sync check, as a resync still overwrites the slot
  always_ff @(posedge clk) begin
    if (byte_take) begin
      if (pos_eff == '0) begin
        byte0 <= rx_byte;
        sum   <= rx_byte;
      end else if (!at_last) begin
        body[wr_idx] <= rx_byte;
        sum          <= sum + rx_byte;
      end
    end
  end

  always_comb begin
    frame.frame_address = body[0];
    frame.command       = body[1];
    frame.frame_rate    = body[2];
    frame.packet_seq    = body[3];
    frame.data_zero     = body[4];
    frame.data_one      = body[5];
    frame.data_two      = body[6];
    frame.data_three    = body[7];
    frame.is_broadcast  = (body[0] != cfg.station_address);
  end

endmodule

`default_nettype wire

>>> hdl/framed_packet_receiver_core.sv
`default_nettype none

// A frame appears on the output in the cycle after its checksum word is taken.
// Throughput: one received word per cycle, sustained; the checksum word alone
// waits while a previous frame still sits unread in the output register.
// Reset (rst, synchronous): frame position to zero, output empty, registers to
// station 2, start byte 2, broadcast 255. Configuration writes are always ready.
module framed_packet_receiver_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fpr_pkg::BYTE_W-1:0]         frame_address,
  output logic [fpr_pkg::BYTE_W-1:0]         command,
  output logic [fpr_pkg::BYTE_W-1:0]         frame_rate,
  output logic [fpr_pkg::BYTE_W-1:0]         packet_seq,
  output logic [fpr_pkg::BYTE_W-1:0]         data_zero,
  output logic [fpr_pkg::BYTE_W-1:0]         data_one,
  output logic [fpr_pkg::BYTE_W-1:0]         data_two,
  output logic [fpr_pkg::BYTE_W-1:0]         data_three,
  output logic                              is_broadcast
);
  import fpr_pkg::*;

  cfg_t   cfg;
  frame_t frame;
  frame_t out_frame;
  logic   byte_take;
  logic   at_last;
  logic   frame_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address   <= STATION_RST;
      cfg.start_byte        <= START_RST;
      cfg.broadcast_address <= BROADCAST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STATION:   cfg.station_address   <= cfg_data;
        REG_START:     cfg.start_byte        <= cfg_data;
        REG_BROADCAST: cfg.broadcast_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the checksum word only while a finished frame is still blocked
  assign in_stall  = at_last && out_valid && out_stall;
  assign byte_take = in_valid && !in_stall;

  fpr_assembler u_asm (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .at_last   (at_last),
    .frame_hit (frame_hit),
    .frame     (frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_hit) begin
      out_frame <= frame;
    end
  end

  assign frame_address = out_frame.frame_address;
  assign command       = out_frame.command;
  assign frame_rate    = out_frame.frame_rate;
  assign packet_seq    = out_frame.packet_seq;
  assign data_zero     = out_frame.data_zero;
  assign data_one      = out_frame.data_one;
  assign data_two      = out_frame.data_two;
  assign data_three    = out_frame.data_three;
  assign is_broadcast  = out_frame.is_broadcast;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpr_pkg::*;

  typedef logic [BODY_LEN-1:0][BYTE_W-1:0]   body_t;  // address .. data_three
  typedef logic [STORED_LEN-1:0][BYTE_W-1:0] held_t;  // start byte .. data_three

  typedef enum logic [1:0] {
    GOOD_SUM,
    BAD_SUM,
    SUM_HITS_START
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_STATION;
  logic [BYTE_W-1:0]     cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     rx_byte   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     frame_address, command, frame_rate, packet_seq;
  logic [BYTE_W-1:0]     data_zero, data_one, data_two, data_three;
  logic                  is_broadcast;

  // receiver state as the block should hold it
  cfg_t          regs    = '{STATION_RST, START_RST, BROADCAST_RST};
  logic [POS_W-1:0] rx_pos = '0;
  held_t         held    = '0;
  frame_t        frames_due[$];

  int  failures = 0;
  logic quiet   = 1'b0;

  framed_packet_receiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_address (frame_address),
    .command       (command),
    .frame_rate    (frame_rate),
    .packet_seq    (packet_seq),
    .data_zero     (data_zero),
    .data_one      (data_one),
    .data_two      (data_two),
    .data_three    (data_three),
    .is_broadcast  (is_broadcast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] byte_sum(input held_t b);
    logic [BYTE_W-1:0] s;
    s = '0;
    for (int k = 0; k < STORED_LEN; k++) s = s + b[k];
    return s;
  endfunction

  function automatic logic [BYTE_W-1:0] frame_checksum(input held_t b);
    logic [BYTE_W-1:0] s;
    s = byte_sum(b);
    // keep the checksum clear of the start byte
    if (s == regs.start_byte) s = s - CSUM_ADJUST;
    return s;
  endfunction

  // advance the expected receiver state by one accepted word
  task automatic take_byte(input logic [BYTE_W-1:0] b);
    logic [POS_W-1:0] p;
    frame_t f;
    p = (rx_pos > LAST_POS) ? '0 : rx_pos;
    if (p != LAST_POS) held[p] = b;
    if (held[0] != regs.start_byte) begin
      rx_pos = '0;
      return;
    end
    if (p != LAST_POS) begin
      rx_pos = p + 1'b1;
      return;
    end
    rx_pos = '0;
    if (frame_checksum(held) != b) return;
    if (held[1] != regs.station_address && held[1] != regs.broadcast_address) return;
    f.frame_address = held[1];
    f.command       = held[2];
    f.frame_rate    = held[3];
    f.packet_seq    = held[4];
    f.data_zero     = held[5];
    f.data_one      = held[6];
    f.data_two      = held[7];
    f.data_three    = held[8];
    f.is_broadcast  = (held[1] != regs.station_address);
    frames_due.push_back(f);
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("frame from address %0h arrived with none expected", frame_address);
        failures++;
      end else begin
        want = frames_due.pop_front();
        check_field("frame_address", want.frame_address, frame_address);
        check_field("command", want.command, command);
        check_field("frame_rate", want.frame_rate, frame_rate);
        check_field("packet_seq", want.packet_seq, packet_seq);
        check_field("data_zero", want.data_zero, data_zero);
        check_field("data_one", want.data_one, data_one);
        check_field("data_two", want.data_two, data_two);
        check_field("data_three", want.data_three, data_three);
        check_field("is_broadcast", 8'(want.is_broadcast), 8'(is_broadcast));
      end
    end
  end

  // output back-pressure in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    take_byte(b);
    @(negedge clk);
  endtask

  // hold input until every expected frame is out and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STATION:   regs.station_address   = v;
      REG_START:     regs.start_byte        = v;
      REG_BROADCAST: regs.broadcast_address = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [BYTE_W-1:0] station, input logic [BYTE_W-1:0] start,
                           input logic [BYTE_W-1:0] bcast);
    settle();
    write_reg(REG_STATION, station);
    write_reg(REG_START, start);
    write_reg(REG_BROADCAST, bcast);
    cfg_valid <= 1'b0;
  endtask

  function automatic body_t body_for(input logic [BYTE_W-1:0] addr);
    body_t b;
    for (int k = 0; k < BODY_LEN; k++) b[k] = BYTE_W'($urandom);
    b[0] = addr;
    return b;
  endfunction

  task automatic send_frame(input body_t body, input frame_kind_t kind);
    held_t fb;
    logic [BYTE_W-1:0] csum;
    // finish off a torn frame so this one lands at position zero
    while (rx_pos != 0) send_byte(BYTE_W'($urandom));
    fb = {body, regs.start_byte};
    if (kind == SUM_HITS_START) fb[8] = fb[8] + (regs.start_byte - byte_sum(fb));
    csum = frame_checksum(fb);
    if (kind == BAD_SUM) csum = csum ^ BYTE_W'($urandom_range(1, 255));
    for (int k = 0; k < STORED_LEN; k++) send_byte(fb[k]);
    send_byte(csum);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic body_t pick_body();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return body_for(regs.station_address);
      4, 5, 6:    return body_for(regs.broadcast_address);
      default:    return body_for(BYTE_W'($urandom));
    endcase
  endfunction

  function automatic frame_kind_t pick_kind();
    case ($urandom_range(0, 9))
      7, 8:    return BAD_SUM;
      9:       return SUM_HITS_START;
      default: return GOOD_SUM;
    endcase
  endfunction

  task automatic test_defaults();
    body_t b;
    b = '1;
    b[0] = STATION_RST;
    send_frame(b, GOOD_SUM);
    b = '0;
    b[0] = BROADCAST_RST;
    send_frame(b, GOOD_SUM);
    send_frame(body_for(8'h07), GOOD_SUM);
  endtask

  task automatic test_checksum();
    send_frame(body_for(regs.station_address), BAD_SUM);
    send_frame(body_for(regs.broadcast_address), SUM_HITS_START);
  endtask

  task automatic test_resync();
    send_byte(8'h00);
    send_byte(8'hA5);
    send_frame(body_for(regs.station_address), GOOD_SUM);
  endtask

  task automatic test_start_change();
    send_byte(regs.start_byte);
    repeat (4) send_byte(BYTE_W'($urandom));
    configure(regs.station_address, 8'h80, regs.broadcast_address);
    send_frame(body_for(regs.station_address), GOOD_SUM);
  endtask

  task automatic test_register_extremes();
    configure(8'h00, 8'h00, 8'hFF);
    send_frame(body_for(8'h00), SUM_HITS_START);
    configure(8'hFF, 8'hFF, 8'h00);
    send_frame(body_for(8'h00), GOOD_SUM);
    send_frame(body_for(8'hFF), SUM_HITS_START);
    // station and broadcast alike: taken as own address
    configure(8'h5C, 8'hA3, 8'h5C);
    send_frame(body_for(8'h5C), GOOD_SUM);
  endtask

  task automatic test_random_traffic();
    logic [BYTE_W-1:0] station;
    repeat (5) begin
      station = pick_byte();
      configure(station, pick_byte(), ($urandom_range(0, 4) == 0) ? station : pick_byte());
      repeat (7) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom));
          1: begin
            // torn frame
            send_byte(regs.start_byte);
            repeat ($urandom_range(0, 7)) send_byte(BYTE_W'($urandom));
          end
          default: send_frame(pick_body(), pick_kind());
        endcase
      end
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (10) send_frame(pick_body(), GOOD_SUM);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_checksum();
    test_resync();
    test_start_change();
    test_register_extremes();
    test_random_traffic();
    test_back_to_back();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
